@@ hdl/i8mm_pkg.sv @@
// Shared types and constants for the int8 matrix multiply block.
// Used by the top level, the multiply-accumulate unit and the port checker.
// No dependencies.
package i8mm_pkg;

  // Field widths of the command, result and configuration words
  localparam int FUNC_W     = 2;
  localparam int IDX_W      = 6;
  localparam int ELEM_W     = 8;
  localparam int PROD_W     = 22;
  localparam int DIM_W      = 5;
  localparam int INNER_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Product of two signed bytes: -128 * -128 still fits in 16 bits signed
  localparam int MUL_W = 2 * ELEM_W;

  // Default store geometry
  localparam int MAX_ROWS_DEF  = 16;
  localparam int MAX_COLS_DEF  = 16;
  localparam int MAX_INNER_DEF = 64;

  // Reset values of the configuration registers
  localparam logic [DIM_W-1:0]   ROWS_RST  = DIM_W'(16);
  localparam logic [DIM_W-1:0]   COLS_RST  = DIM_W'(16);
  localparam logic [INNER_W-1:0] INNER_RST = INNER_W'(64);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_INNER = CFG_IDX_W'(2);

  // Result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Command function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_A  = 2'd0,
    FUNC_LOAD_B  = 2'd1,
    FUNC_COMPUTE = 2'd2
  } i8mm_func_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } i8mm_state_e;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic valid;
  } i8mm_mac_ctl_t;

endpackage

@@ hdl/int8_matrix_multiply_int32.sv @@
// Signed int8 matrix multiply with wide accumulation, one result element per compute command.
// Depends on i8mm_pkg and i8mm_mac; holds the A and B element stores.
//
// Use: a command word is taken at a rising edge with start_i high and busy_o low.
// func_i selects load A element, load B element or compute one result element at
// (row_index_i, col_index_i). Loads give no result and are dropped when the indices
// fall outside the store. A compute outside the configured rows or columns gives
// status_o = 1 with product_value_o = 0 on the next cycle, and busy_o stays low.
// A valid compute walks the inner dimension with one shared multiplier, one store
// read pair per cycle, over L elements where L is inner_len limited to MAX_INNER;
// busy_o stays high until the result shows, and falls in the cycle the result shows.
// A new command is not taken until the running compute has finished.
// Each result is on the ports for exactly one cycle with result_valid_o high; the
// receiver cannot stall it, and the next command may be taken in that same cycle.
// Configuration words (rows_in_use, cols_in_use, inner_len at index 0..2) go in on
// cfg_valid_i/cfg_ready_o while the block is idle; index 3 is ignored.
// Reset returns the registers to 16, 16, 64 and the sequencer to idle; the element
// stores are not cleared and must be loaded before use.
module int8_matrix_multiply_int32 #(
  parameter int MAX_ROWS  = i8mm_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS  = i8mm_pkg::MAX_COLS_DEF,
  parameter int MAX_INNER = i8mm_pkg::MAX_INNER_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  output logic                                    busy_o,
  input  logic [i8mm_pkg::FUNC_W-1:0]             func_i,
  input  logic [i8mm_pkg::IDX_W-1:0]              row_index_i,
  input  logic [i8mm_pkg::IDX_W-1:0]              col_index_i,
  input  logic signed [i8mm_pkg::ELEM_W-1:0]      elem_value_i,
  output logic                                    result_valid_o,
  output logic signed [i8mm_pkg::PROD_W-1:0]      product_value_o,
  output logic                                    status_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [i8mm_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [i8mm_pkg::CFG_DATA_W-1:0]         cfg_data_i
);
  import i8mm_pkg::*;

  localparam int LEFT_DEPTH  = MAX_ROWS * MAX_INNER;
  localparam int RIGHT_DEPTH = MAX_INNER * MAX_COLS;
  localparam int LEFT_AW     = (LEFT_DEPTH > 1) ? $clog2(LEFT_DEPTH) : 1;
  localparam int RIGHT_AW    = (RIGHT_DEPTH > 1) ? $clog2(RIGHT_DEPTH) : 1;
  localparam int ACC_RAW     = MUL_W + 1 + $clog2(MAX_INNER + 1);
  localparam int ACC_W       = (ACC_RAW > PROD_W + 1) ? ACC_RAW : PROD_W + 1;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (PROD_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(2 ** (PROD_W - 1));

  i8mm_state_e state_q, state_d;

  logic [DIM_W-1:0]   rows_q, cols_q;
  logic [INNER_W-1:0] inner_q;

  logic [INNER_W-1:0] k_q, k_d;
  logic [INNER_W-1:0] len_q, len_d;
  logic [IDX_W-1:0]   row_q, row_d, col_q, col_d;
  logic               strobe_q, strobe_d;
  logic               status_q, status_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;

  logic [ELEM_W-1:0]  left_mem  [LEFT_DEPTH];
  logic [ELEM_W-1:0]  right_mem [RIGHT_DEPTH];
  logic signed [ELEM_W-1:0] left_rd_q, right_rd_q;
  logic               rd_vld_q;

  logic               accept, range_err, left_ok, right_ok;
  logic               left_we, right_we, rd_en;
  logic [LEFT_AW-1:0]  left_waddr, left_raddr;
  logic [RIGHT_AW-1:0] right_waddr, right_raddr;
  logic [INNER_W-1:0] inner_eff;

  i8mm_mac_ctl_t           mac_ctl;
  logic signed [ACC_W-1:0] acc;
  logic                    mac_busy;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);

  // Limit the registers to the store geometry
  assign inner_eff = (32'(inner_q) > MAX_INNER) ? INNER_W'(MAX_INNER) : inner_q;
  assign range_err = (32'(row_index_i) >= 32'(rows_q)) || (32'(row_index_i) >= MAX_ROWS) ||
                     (32'(col_index_i) >= 32'(cols_q)) || (32'(col_index_i) >= MAX_COLS);
  assign left_ok   = (32'(row_index_i) < MAX_ROWS) && (32'(col_index_i) < MAX_INNER);
  assign right_ok  = (32'(row_index_i) < MAX_INNER) && (32'(col_index_i) < MAX_COLS);

  // Store addresses: A row-major over the inner length, B row-major over columns
  assign left_waddr  = LEFT_AW'(32'(row_index_i) * MAX_INNER + 32'(col_index_i));
  assign right_waddr = RIGHT_AW'(32'(row_index_i) * MAX_COLS + 32'(col_index_i));
  assign left_raddr  = LEFT_AW'(32'(row_q) * MAX_INNER + 32'(k_q));
  assign right_raddr = RIGHT_AW'(32'(k_q) * MAX_COLS + 32'(col_q));

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= ROWS_RST;
      cols_q  <= COLS_RST;
      inner_q <= INNER_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ROWS:  rows_q  <= cfg_data_i[DIM_W-1:0];
        CFG_COLS:  cols_q  <= cfg_data_i[DIM_W-1:0];
        CFG_INNER: inner_q <= cfg_data_i[INNER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: decode commands, walk the inner dimension, wait out the pipeline
  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    len_d    = len_q;
    row_d    = row_q;
    col_d    = col_q;
    strobe_d = 1'b0;
    status_d = status_q;
    prod_d   = prod_q;
    left_we  = 1'b0;
    right_we = 1'b0;
    rd_en    = 1'b0;
    mac_ctl  = '{clear: 1'b0, valid: rd_vld_q};

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_i)
            FUNC_LOAD_A:  left_we  = left_ok;
            FUNC_LOAD_B:  right_we = right_ok;
            FUNC_COMPUTE: begin
              if (range_err) begin
                strobe_d = 1'b1;
                status_d = STATUS_RANGE;
                prod_d   = '0;
              end else begin
                mac_ctl.clear = 1'b1;
                row_d         = row_index_i;
                col_d         = col_index_i;
                k_d           = '0;
                len_d         = inner_eff;
                state_d       = (inner_eff == '0) ? ST_DRAIN : ST_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        rd_en = 1'b1;
        k_d   = k_q + INNER_W'(1);
        if (k_d == len_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !mac_busy) begin
          strobe_d = 1'b1;
          status_d = STATUS_OK;
          if (acc > SAT_HI) begin
            prod_d = SAT_HI[PROD_W-1:0];
          end else if (acc < SAT_LO) begin
            prod_d = SAT_LO[PROD_W-1:0];
          end else begin
            prod_d = acc[PROD_W-1:0];
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      rd_vld_q <= rd_en;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    len_q    <= len_d;
    row_q    <= row_d;
    col_q    <= col_d;
    status_q <= status_d;
    prod_q   <= prod_d;
  end

  // Element stores: one write port each, registered read
  always_ff @(posedge clk_i) begin
    if (left_we) begin
      left_mem[left_waddr] <= elem_value_i;
    end
    if (rd_en) begin
      left_rd_q <= left_mem[left_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (right_we) begin
      right_mem[right_waddr] <= elem_value_i;
    end
    if (rd_en) begin
      right_rd_q <= right_mem[right_raddr];
    end
  end

  i8mm_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (left_rd_q),
    .b_i    (right_rd_q),
    .acc_o  (acc),
    .busy_o (mac_busy)
  );

  assign result_valid_o  = strobe_q;
  assign product_value_o = prod_q;
  assign status_o        = status_q;

endmodule

@@ hdl/i8mm_mac.sv @@
// Shared signed 8x8 multiply-accumulate unit with a registered product stage.
// Depends on i8mm_pkg for widths and the control struct.
module i8mm_mac #(
  parameter int ACC_W = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  i8mm_pkg::i8mm_mac_ctl_t              ctl_i,
  input  logic signed [i8mm_pkg::ELEM_W-1:0]   a_i,
  input  logic signed [i8mm_pkg::ELEM_W-1:0]   b_i,
  output logic signed [ACC_W-1:0]              acc_o,
  output logic                                 busy_o
);
  import i8mm_pkg::*;

  logic signed [MUL_W-1:0] prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                    prod_vld_q;

  // Track a product in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctl_i.valid;
    end
  end

  // Multiply, then add the registered product into the sum
  always_ff @(posedge clk_i) begin
    prod_q <= MUL_W'(a_i * b_i);
    if (ctl_i.clear) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = prod_vld_q;

endmodule

@@ hdl/i8mm_checker.sv @@
// Port-level checks for the int8 matrix multiply block, bound to the top level.
// Depends on i8mm_pkg and int8_matrix_multiply_int32.
module i8mm_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start_i,
  input logic                                 busy_o,
  input logic [i8mm_pkg::FUNC_W-1:0]          func_i,
  input logic                                 result_valid_o,
  input logic signed [i8mm_pkg::PROD_W-1:0]   product_value_o,
  input logic                                 status_o
);
  import i8mm_pkg::*;

  // An error result carries a zero sum
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == STATUS_RANGE)) |-> (product_value_o == '0))
    else $error("error result with nonzero sum");

  // A finished compute hands out its result as busy drops
  a_done_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> result_valid_o)
    else $error("compute finished without a result word");

  // Loads and unused codes give no result and never block
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (func_i != FUNC_COMPUTE)) |=> (!busy_o && !result_valid_o))
    else $error("load or unused code produced a result or went busy");

  // No result word while a compute is still at work
  a_busy_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !result_valid_o)
    else $error("result word shown while busy");

endmodule

bind int8_matrix_multiply_int32 i8mm_checker u_chk (.*);

@@ tb/sv/int8_gemm_checker.sv @@
`timescale 1ns / 1ps
// Port checker for int8_matrix_multiply_int32: mirrors both element stores and the size
// registers, predicts each result word and compares it when the strobe shows it.
// Depends on i8mm_pkg.
module int8_gemm_checker #(
  parameter int MAX_ROWS  = i8mm_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS  = i8mm_pkg::MAX_COLS_DEF,
  parameter int MAX_INNER = i8mm_pkg::MAX_INNER_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic                                  busy_i,
  input  logic [i8mm_pkg::FUNC_W-1:0]           func_i,
  input  logic [i8mm_pkg::IDX_W-1:0]            row_index_i,
  input  logic [i8mm_pkg::IDX_W-1:0]            col_index_i,
  input  logic signed [i8mm_pkg::ELEM_W-1:0]    elem_value_i,
  input  logic                                  result_valid_i,
  input  logic signed [i8mm_pkg::PROD_W-1:0]    product_value_i,
  input  logic                                  status_i,
  input  logic                                  cfg_valid_i,
  input  logic                                  cfg_ready_i,
  input  logic [i8mm_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [i8mm_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output int                                    fail_count_o,
  output int                                    pending_o
);
  import i8mm_pkg::*;

  localparam longint SUM_MAX = (64'sd1 <<< (PROD_W - 1)) - 1;
  localparam longint SUM_MIN = -(64'sd1 <<< (PROD_W - 1));

  typedef struct packed {
    logic signed [PROD_W-1:0] product;
    logic                     status;
  } element_t;

  // Mirror of A (row-major, MAX_INNER wide) and B (row-major, MAX_COLS wide)
  logic signed [ELEM_W-1:0] a_elems [MAX_ROWS*MAX_INNER];
  logic signed [ELEM_W-1:0] b_elems [MAX_INNER*MAX_COLS];
  logic [DIM_W-1:0]         rows_q;
  logic [DIM_W-1:0]         cols_q;
  logic [INNER_W-1:0]       inner_q;
  element_t                 pending_elements [$];

  // Work out one element of C = A x B under the current sizes
  function automatic element_t dot_element(input logic [IDX_W-1:0] row,
                                           input logic [IDX_W-1:0] col);
    int unsigned rows;
    int unsigned cols;
    int unsigned depth;
    int unsigned k;
    longint      acc;
    element_t    res;
    rows  = (rows_q > MAX_ROWS) ? MAX_ROWS : rows_q;
    cols  = (cols_q > MAX_COLS) ? MAX_COLS : cols_q;
    depth = (inner_q > MAX_INNER) ? MAX_INNER : inner_q;
    res.product = '0;
    res.status  = STATUS_OK;
    if (row >= rows || col >= cols) begin
      res.status = STATUS_RANGE;
      return res;
    end
    acc = 0;
    for (k = 0; k < depth; k++) begin
      acc += longint'(a_elems[row * MAX_INNER + k]) * longint'(b_elems[k * MAX_COLS + col]);
    end
    // Clip to the result field
    if (acc > SUM_MAX) acc = SUM_MAX;
    if (acc < SUM_MIN) acc = SUM_MIN;
    res.product = acc[PROD_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i) begin
    element_t want;
    if (!rst_ni) begin
      rows_q  = ROWS_RST;
      cols_q  = COLS_RST;
      inner_q = INNER_RST;
      pending_elements.delete();
    end else begin
      // Match the result word against the oldest prediction
      if (result_valid_i) begin
        if (pending_elements.size() == 0) begin
          $error("unexpected result word: product_value %0d status %0b",
                 product_value_i, status_i);
          fail_count_o++;
        end else begin
          want = pending_elements.pop_front();
          if (product_value_i !== want.product) begin
            $error("product_value: expected %0d, actual %0d", want.product, product_value_i);
            fail_count_o++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0b, actual %0b", want.status, status_i);
            fail_count_o++;
          end
        end
      end
      // Apply the accepted command word under the sizes held before this edge
      if (start_i && !busy_i) begin
        case (func_i)
          FUNC_LOAD_A: begin
            if (row_index_i < MAX_ROWS && col_index_i < MAX_INNER)
              a_elems[row_index_i * MAX_INNER + col_index_i] = elem_value_i;
          end
          FUNC_LOAD_B: begin
            if (row_index_i < MAX_INNER && col_index_i < MAX_COLS)
              b_elems[row_index_i * MAX_COLS + col_index_i] = elem_value_i;
          end
          FUNC_COMPUTE: pending_elements.push_back(dot_element(row_index_i, col_index_i));
          default: ;
        endcase
      end
      // Track register writes; the spare index is ignored
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ROWS:  rows_q = cfg_data_i[DIM_W-1:0];
          CFG_COLS:  cols_q = cfg_data_i[DIM_W-1:0];
          CFG_INNER: inner_q = cfg_data_i[INNER_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o = pending_elements.size();
  end

endmodule

@@ tb/sv/int8_matrix_multiply_int32_test.sv @@
`timescale 1ns / 1ps
// Regression top for int8_matrix_multiply_int32: clock, reset, command and register
// stimulus and the verdict. Depends on i8mm_pkg, the block and int8_gemm_checker.
module int8_matrix_multiply_int32_test;
  import i8mm_pkg::*;

  localparam int     CLK_HIGH     = 6;
  localparam int     CLK_LOW      = 6;
  localparam int     MAX_ROWS     = MAX_ROWS_DEF;
  localparam int     MAX_COLS     = MAX_COLS_DEF;
  localparam int     MAX_INNER    = MAX_INNER_DEF;
  localparam int     RANDOM_WORDS = 700;
  localparam int     PHASE_WORDS  = 120;
  localparam int     DRAIN_CYCLES = MAX_INNER + 8;
  localparam longint RUN_LIMIT_NS = 64'd12_000_000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = CFG_IDX_W'(3);
  localparam logic [FUNC_W-1:0]    FUNC_SPARE = FUNC_W'(3);

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic                     busy_o;
  logic [FUNC_W-1:0]        func_i = '0;
  logic [IDX_W-1:0]         row_index_i = '0;
  logic [IDX_W-1:0]         col_index_i = '0;
  logic signed [ELEM_W-1:0] elem_value_i = '0;
  logic                     result_valid_o;
  logic signed [PROD_W-1:0] product_value_o;
  logic                     status_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]    cfg_data_i = '0;
  int                       fail_count;
  int                       pending;

  // Which store entries hold a written element, so computes never read garbage
  bit          a_loaded [MAX_ROWS][MAX_INNER];
  bit          b_loaded [MAX_INNER][MAX_COLS];
  int unsigned rows_eff;
  int unsigned cols_eff;
  int unsigned depth_eff;
  bit          idle_gaps;
  int          useful_words;

  int8_matrix_multiply_int32 dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .func_i          (func_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .elem_value_i    (elem_value_i),
    .result_valid_o  (result_valid_o),
    .product_value_o (product_value_o),
    .status_o        (status_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  int8_gemm_checker #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .MAX_INNER (MAX_INNER)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .func_i          (func_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .elem_value_i    (elem_value_i),
    .result_valid_i  (result_valid_o),
    .product_value_i (product_value_o),
    .status_i        (status_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always begin
    clk_i = 1'b0;
    #CLK_LOW;
    clk_i = 1'b1;
    #CLK_HIGH;
  end

  // Hold one command word until the block takes it; called and returns at a falling edge
  task automatic send_word(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic signed [ELEM_W-1:0] elem);
    int gap;
    gap = idle_gaps ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    func_i       = func;
    row_index_i  = row;
    col_index_i  = col;
    elem_value_i = elem;
    start_i      = 1'b1;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    if (func == FUNC_LOAD_A && row < MAX_ROWS && col < MAX_INNER) begin
      a_loaded[row][col] = 1'b1;
      useful_words++;
    end else if (func == FUNC_LOAD_B && row < MAX_INNER && col < MAX_COLS) begin
      b_loaded[row][col] = 1'b1;
      useful_words++;
    end else if (func == FUNC_COMPUTE) begin
      useful_words++;
    end
  endtask

  // Load every operand the requested element reads that is still unwritten, then compute
  task automatic prepare_and_compute(input int row, input int col);
    int k;
    if (row < rows_eff && col < cols_eff) begin
      for (k = 0; k < depth_eff; k++) begin
        if (!a_loaded[row][k])
          send_word(FUNC_LOAD_A, IDX_W'(row), IDX_W'(k), ELEM_W'($urandom()));
        if (!b_loaded[k][col])
          send_word(FUNC_LOAD_B, IDX_W'(k), IDX_W'(col), ELEM_W'($urandom()));
      end
    end
    send_word(FUNC_COMPUTE, IDX_W'(row), IDX_W'(col), ELEM_W'($urandom()));
  endtask

  // Push one register word through the write channel
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_index_i = idx;
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    if (idx == CFG_ROWS)
      rows_eff = (data[DIM_W-1:0] > MAX_ROWS) ? MAX_ROWS : data[DIM_W-1:0];
    else if (idx == CFG_COLS)
      cols_eff = (data[DIM_W-1:0] > MAX_COLS) ? MAX_COLS : data[DIM_W-1:0];
    else if (idx == CFG_INNER)
      depth_eff = (data[INNER_W-1:0] > MAX_INNER) ? MAX_INNER : data[INNER_W-1:0];
  endtask

  // Drop start, wait for every prediction to be met, then let a full compute time pass
  task automatic settle();
    start_i = 1'b0;
    while (pending != 0 || busy_o) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_sizes(input logic [CFG_DATA_W-1:0] rows,
                           input logic [CFG_DATA_W-1:0] cols,
                           input logic [CFG_DATA_W-1:0] depth);
    settle();
    if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom()));
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_COLS, cols);
    write_reg(CFG_INNER, depth);
  endtask

  // Mostly well-formed computes with their operands, plus loads and noise
  task automatic random_phase(input int words);
    int stop;
    int pick;
    int row;
    int col;
    stop = useful_words + words;
    while (useful_words < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        prepare_and_compute($urandom_range(0, rows_eff), $urandom_range(0, cols_eff));
      end else if (pick < 85) begin
        if ($urandom_range(0, 1) == 0) begin
          row = $urandom_range(0, MAX_ROWS - 1);
          col = $urandom_range(0, MAX_INNER - 1);
          send_word(FUNC_LOAD_A, IDX_W'(row), IDX_W'(col), ELEM_W'($urandom()));
        end else begin
          row = $urandom_range(0, MAX_INNER - 1);
          col = $urandom_range(0, MAX_COLS - 1);
          send_word(FUNC_LOAD_B, IDX_W'(row), IDX_W'(col), ELEM_W'($urandom()));
        end
      end else if (pick < 90) begin
        send_word($urandom_range(0, 1) ? FUNC_LOAD_A : FUNC_LOAD_B,
                  IDX_W'($urandom()), IDX_W'($urandom()), ELEM_W'($urandom()));
      end else if (pick < 95) begin
        send_word(FUNC_SPARE, IDX_W'($urandom()), IDX_W'($urandom()), ELEM_W'($urandom()));
      end else begin
        prepare_and_compute($urandom_range(0, 63), $urandom_range(0, 63));
      end
    end
  endtask

  initial begin
    int k;
    int goal;
    rows_eff  = MAX_ROWS;
    cols_eff  = MAX_COLS;
    depth_eff = MAX_INNER;
    idle_gaps = 1'b1;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Single-step inner length: corner bytes, dropped loads, spare code, range errors
    set_sizes(7'd16, 7'd16, 7'd1);
    send_word(FUNC_LOAD_A, 6'd0, 6'd0, -8'sd128);
    send_word(FUNC_LOAD_B, 6'd0, 6'd0, -8'sd128);
    send_word(FUNC_COMPUTE, 6'd0, 6'd0, 8'sd0);
    send_word(FUNC_LOAD_A, 6'd0, 6'd0, 8'sd127);
    send_word(FUNC_COMPUTE, 6'd0, 6'd0, -8'sd1);
    send_word(FUNC_LOAD_A, 6'd15, 6'd0, 8'sd127);
    send_word(FUNC_LOAD_B, 6'd0, 6'd15, 8'sd127);
    send_word(FUNC_COMPUTE, 6'd15, 6'd15, 8'sd0);
    send_word(FUNC_LOAD_A, 6'd15, 6'd63, -8'sd1);
    send_word(FUNC_LOAD_B, 6'd63, 6'd15, 8'sd0);
    send_word(FUNC_LOAD_A, 6'd16, 6'd0, 8'sd5);
    send_word(FUNC_LOAD_A, 6'd63, 6'd63, 8'sd5);
    send_word(FUNC_LOAD_B, 6'd0, 6'd16, 8'sd5);
    send_word(FUNC_LOAD_B, 6'd63, 6'd63, 8'sd5);
    send_word(FUNC_SPARE, 6'd63, 6'd63, -8'sd1);
    send_word(FUNC_SPARE, 6'd0, 6'd0, 8'sd0);
    send_word(FUNC_COMPUTE, 6'd16, 6'd0, 8'sd0);
    send_word(FUNC_COMPUTE, 6'd0, 6'd16, 8'sd0);
    send_word(FUNC_COMPUTE, 6'd63, 6'd63, 8'sd0);
    send_word(FUNC_COMPUTE, 6'd15, 6'd15, 8'sd0);

    // Full inner length: largest and smallest sums, back to back with no gaps
    set_sizes(7'd16, 7'd16, 7'd64);
    idle_gaps = 1'b0;
    for (k = 0; k < MAX_INNER; k++) begin
      send_word(FUNC_LOAD_A, 6'd1, IDX_W'(k), -8'sd128);
      send_word(FUNC_LOAD_B, IDX_W'(k), 6'd1, -8'sd128);
    end
    send_word(FUNC_COMPUTE, 6'd1, 6'd1, 8'sd0);
    for (k = 0; k < MAX_INNER; k++) send_word(FUNC_LOAD_A, 6'd2, IDX_W'(k), 8'sd127);
    send_word(FUNC_COMPUTE, 6'd2, 6'd1, 8'sd0);
    send_word(FUNC_COMPUTE, 6'd1, 6'd1, 8'sd0);
    idle_gaps = 1'b1;

    // Zero rows, then zero columns: every compute is a range error
    set_sizes(7'd0, 7'd16, 7'd4);
    for (k = 0; k < 4; k++) prepare_and_compute($urandom_range(0, 16), $urandom_range(0, 16));
    set_sizes(7'd16, 7'd0, 7'd4);
    for (k = 0; k < 4; k++) prepare_and_compute($urandom_range(0, 16), $urandom_range(0, 16));

    // Zero inner length: empty sums
    set_sizes(7'd5, 7'd7, 7'd0);
    for (k = 0; k < 6; k++) prepare_and_compute($urandom_range(0, 5), $urandom_range(0, 7));

    // All register bits set: sizes clip to the store geometry
    set_sizes(7'h7F, 7'h7F, 7'h7F);
    prepare_and_compute(1, 1);
    prepare_and_compute(2, 1);
    prepare_and_compute($urandom_range(0, 3), $urandom_range(0, 3));
    prepare_and_compute(16, 15);

    // Random sizes, mostly short inner lengths, with and without idle gaps
    goal = useful_words + RANDOM_WORDS;
    while (useful_words < goal) begin
      set_sizes({2'($urandom_range(0, 3)), 5'($urandom_range(1, 16))},
                {2'($urandom_range(0, 3)), 5'($urandom_range(1, 16))},
                ($urandom_range(0, 5) == 0) ? 7'($urandom_range(13, 64))
                                            : 7'($urandom_range(1, 12)));
      idle_gaps = ($urandom_range(0, 3) != 0);
      random_phase(PHASE_WORDS);
    end

    settle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop for a hung handshake or a missing result
  initial begin
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
